// ===== rtl/csr_pkg.sv =====
// Shared widths, codes and reset values for the raised-cosine servo ramp.
package csr_pkg;

    localparam int DUTY_W    = 14;
    localparam int WEIGHT_W  = 17;
    localparam int CFG_IDX_W = 1;

    typedef logic [DUTY_W-1:0]   duty_t;
    typedef logic [WEIGHT_W-1:0] weight_t;

    // Command and position codes of an input transaction.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;
    localparam logic POS_OUT  = 1'b0;
    localparam logic POS_BACK = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_OUT_DUTY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_DUTY = 1'b1;

    localparam duty_t OUT_DUTY_RESET  = 14'd570;
    localparam duty_t BACK_DUTY_RESET = 14'd1250;

endpackage

// ===== rtl/csr_weight_rom.sv =====
// Weight ROM: Q1.16 raised-cosine weight per ramp step, registered read.
module csr_weight_rom #(
    parameter int RAMP_TICKS = 350
) (
    input  logic                               aclk,
    input  logic [$clog2(RAMP_TICKS+1)-1:0]    rd_addr,
    output csr_pkg::weight_t                   rd_data
);
    import csr_pkg::*;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    typedef weight_t wtab_t [RAMP_TICKS+1];

    function automatic logic [63:0] one_minus(input logic [63:0] t);
        return (t >= ONE_Q30) ? 64'd0 : ONE_Q30 - t;
    endfunction

    // Evaluated at elaboration: sin^2 of the half angle through a Horner
    // series in Q2.30, then rounded to Q1.16 and saturated at one.
    function automatic wtab_t build_table();
        wtab_t       tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] s;
        logic [63:0] w;
        for (int c = 0; c <= RAMP_TICKS; c++) begin
            x  = (64'(c) * PI_Q30 + 64'(RAMP_TICKS)) / 64'(2 * RAMP_TICKS);
            x2 = (x * x) >> 30;
            s  = one_minus(((x2 / 156) * ONE_Q30) >> 30);
            s  = one_minus(((x2 / 110) * s) >> 30);
            s  = one_minus(((x2 / 72) * s) >> 30);
            s  = one_minus(((x2 / 42) * s) >> 30);
            s  = one_minus(((x2 / 20) * s) >> 30);
            s  = one_minus(((x2 / 6) * s) >> 30);
            s  = (x * s) >> 30;
            w  = (s * s) >> 30;
            w  = (w + 64'd8192) >> 14;
            if (w > 64'd65536) begin
                w = 64'd65536;
            end
            tab[c] = w[WEIGHT_W-1:0];
        end
        return tab;
    endfunction

    localparam wtab_t WEIGHT_TABLE = build_table();

    weight_t rd_data_reg;

    always_ff @(posedge aclk) begin
        rd_data_reg <= WEIGHT_TABLE[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/cosine_servo_ramp.sv =====
// Top level of the raised-cosine servo duty ramp with its output buffer.
//
// The block drives one servo duty value in hundredths of a percent. Each
// input transaction on the s_ channel is either a timer tick (s_cmd low) or
// a set command (s_cmd high) that picks the out or back duty by s_position.
// The first set after reset jumps straight to the chosen duty and returns it.
// Every later set latches the chosen duty as the target and starts a ramp.
// While the ramp runs, each tick returns now + (target - now) * w, where w
// follows a raised cosine over RAMP_TICKS + 1 ticks; after the last tick the
// current duty becomes the target. Ticks outside a ramp and later sets
// return nothing. Results leave on the m_ channel.
// A result is registered into the output buffer, and one transaction is
// taken every cycle while s_ready is high: the weight for the coming step
// is read ahead from a registered ROM, so a tick needs only one multiply.
// A two-entry output buffer keeps s_ready high while one result waits on a
// stalled receiver; s_ready drops only when both entries are full.
// The cfg_ port writes out_duty (index 0) and back_duty (index 1). Reset
// loads the default duties, clears the ramp, empties the output buffer
// and arms the first-set jump.
module cosine_servo_ramp #(
    parameter int RAMP_TICKS = 350
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_cmd,
    input  logic                              s_position,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [csr_pkg::DUTY_W-1:0]        m_duty,
    input  logic                              cfg_wr_en,
    input  logic [csr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [csr_pkg::DUTY_W-1:0]        cfg_wdata
);
    import csr_pkg::*;

    localparam int ADDR_W = $clog2(RAMP_TICKS + 1);
    localparam logic [ADDR_W-1:0] LAST_STEP = ADDR_W'(RAMP_TICKS);

    // Configuration registers.
    duty_t out_duty_reg;
    duty_t back_duty_reg;

    // Ramp state.
    duty_t             now_duty_reg,  now_duty_next;
    duty_t             target_reg,    target_next;
    logic              active_reg,    active_next;
    logic              first_reg,     first_next;
    logic [ADDR_W-1:0] count_reg,     count_next;

    // Output buffer: a main register and a skid entry behind it.
    logic  m_valid_reg, m_valid_next;
    duty_t m_duty_reg,  m_duty_next;
    logic  skid_valid_reg, skid_valid_next;
    duty_t skid_duty_reg,  skid_duty_next;

    logic              accept;
    logic              emit;
    duty_t             result;
    duty_t             set_duty;
    weight_t           weight;
    logic [ADDR_W-1:0] rom_addr;

    logic signed [DUTY_W:0]  diff;
    logic signed [31:0]      prod;
    logic signed [31:0]      rounded;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_duty  = m_duty_reg;

    // The ROM is addressed with the step count of the next cycle, so the
    // registered weight always belongs to the current count.
    assign rom_addr = aresetn ? count_next : '0;

    csr_weight_rom #(
        .RAMP_TICKS (RAMP_TICKS)
    ) u_weight_rom (
        .aclk    (aclk),
        .rd_addr (rom_addr),
        .rd_data (weight)
    );

    assign set_duty = (s_position == POS_BACK) ? back_duty_reg : out_duty_reg;

    // Interpolated duty: now + round((target - now) * w / 65536), with a tie
    // rounding up. The arithmetic shift floors the biased product.
    assign diff    = $signed({1'b0, target_reg}) - $signed({1'b0, now_duty_reg});
    assign prod    = 32'(diff) * $signed({15'd0, weight});
    assign rounded = (prod + 32'sd32768) >>> 16;

    always_comb begin
        now_duty_next = now_duty_reg;
        target_next   = target_reg;
        active_next   = active_reg;
        first_next    = first_reg;
        count_next    = count_reg;
        emit          = 1'b0;
        result        = now_duty_reg + rounded[DUTY_W-1:0];
        if (accept) begin
            if (s_cmd == CMD_SET) begin
                if (first_reg) begin
                    now_duty_next = set_duty;
                    first_next    = 1'b0;
                    emit          = 1'b1;
                    result        = set_duty;
                end else begin
                    target_next = set_duty;
                    active_next = 1'b1;
                end
            end else if (active_reg) begin
                emit = 1'b1;
                if (count_reg >= LAST_STEP) begin
                    count_next    = '0;
                    active_next   = 1'b0;
                    now_duty_next = target_reg;
                end else begin
                    count_next = count_reg + ADDR_W'(1);
                end
            end
        end
    end

    always_comb begin
        m_valid_next    = m_valid_reg;
        m_duty_next     = m_duty_reg;
        skid_valid_next = skid_valid_reg;
        skid_duty_next  = skid_duty_reg;
        if (m_valid_reg && m_ready) begin
            if (skid_valid_reg) begin
                m_duty_next     = skid_duty_reg;
                skid_valid_next = 1'b0;
            end else begin
                m_valid_next = 1'b0;
            end
        end
        if (emit) begin
            if (!m_valid_next) begin
                m_valid_next = 1'b1;
                m_duty_next  = result;
            end else begin
                skid_valid_next = 1'b1;
                skid_duty_next  = result;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_duty_reg   <= OUT_DUTY_RESET;
            back_duty_reg  <= BACK_DUTY_RESET;
            now_duty_reg   <= '0;
            target_reg     <= '0;
            active_reg     <= 1'b0;
            first_reg      <= 1'b1;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_OUT_DUTY:  out_duty_reg  <= cfg_wdata;
                    REG_BACK_DUTY: back_duty_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            now_duty_reg   <= now_duty_next;
            target_reg     <= target_next;
            active_reg     <= active_next;
            first_reg      <= first_next;
            count_reg      <= count_next;
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_duty_reg    <= m_duty_next;
        skid_duty_reg <= skid_duty_next;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= LAST_STEP)
        else $error("ramp step count ran past the last step");

    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry holds a result while the main register is empty");

    a_ramp_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_cmd == CMD_TICK && active_reg && count_reg == LAST_STEP)
        |=> (!active_reg && now_duty_reg == $past(target_reg)))
        else $error("ramp did not settle on the target after its last step");

    a_first_set: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(first_reg) |-> $past(accept && s_cmd == CMD_SET))
        else $error("first-set jump cleared without a set transaction");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && skid_valid_reg && !m_ready) |=> skid_valid_reg)
        else $error("buffered result dropped while the receiver stalled");
`endif

endmodule
